[rtl/core/oid_pkg.sv]
// Shared types, codes and frame check for the optical-ID two-wire host.
// No dependencies; imported by every module of the block.
package oid_pkg;

    localparam int TICK_W    = 16;
    localparam int HP_W      = 16;
    localparam int FRAME_W   = 23;
    localparam int CODE_W    = 17;
    localparam int CMD_W     = 8;
    localparam int TX_W      = CMD_W + 1;
    localparam int BITCNT_W  = 5;
    localparam int STATUS_W  = 3;
    localparam int OPCODE_W  = 2;
    localparam int PHASE_W   = 4;

    localparam logic [HP_W-1:0]     HP_RESET   = HP_W'(48);
    localparam logic [BITCNT_W-1:0] FRAME_BITS = BITCNT_W'(FRAME_W);
    localparam logic [BITCNT_W-1:0] TX_BITS    = BITCNT_W'(TX_W);

    localparam logic [OPCODE_W-1:0] OP_NONE = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_POLL = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_CMD  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_NONE      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_READY = 3'd1;
    localparam logic [STATUS_W-1:0] ST_VALID     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CMD_SENT  = 3'd4;

    localparam logic [6:0]  HDR_LOW_MASK = 7'h03;
    localparam logic [6:0]  HDR_SET_MASK = 7'h40;
    localparam logic [6:0]  HDR_CLR_MASK = 7'h20;
    localparam logic [15:0] LOW_LIMIT_A  = 16'hFFFB;
    localparam logic [15:0] LOW_ALL_ONES = 16'hFFFF;

    typedef struct packed {
        logic                sck;
        logic                sda_out;
        logic                sda_drive;
        logic                busy;
        logic [STATUS_W-1:0] status;
        logic [FRAME_W-1:0]  frame;
        logic [CODE_W-1:0]   code;
    } result_t;

    function automatic logic [STATUS_W-1:0] frame_check(input logic [FRAME_W-1:0] f);
        logic [6:0]  hi;
        logic [15:0] lo;
        logic [STATUS_W-1:0] st;
        hi = f[22:16];
        lo = f[15:0];
        st = ST_VALID;
        if (hi == 7'd0 && lo == 16'd0)
        begin
            st = ST_INVALID;
        end
        else if ((hi & HDR_LOW_MASK) != 7'd0)
        begin
            if (lo >= LOW_LIMIT_A)
            begin
                st = ST_INVALID;
            end
        end
        else if ((hi & HDR_SET_MASK) == 7'd0 || (hi & HDR_CLR_MASK) != 7'd0)
        begin
            st = ST_INVALID;
        end
        else if (lo == LOW_ALL_ONES)
        begin
            st = ST_INVALID;
        end
        return st;
    endfunction

endpackage

[rtl/core/oid_core.sv]
// Link sequencer: phase, tick and bit counters, shift registers, one tick per item.
// Depends on oid_pkg.
module oid_core
    import oid_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [HP_W-1:0]     hp_cfg,
    input  logic                advance,
    input  logic [OPCODE_W-1:0] opcode,
    input  logic [CMD_W-1:0]    cmd_byte,
    input  logic                sda_in,
    output result_t             result
);

    localparam int CMP_W = (TICK_W + 1 > HP_W) ? TICK_W + 1 : HP_W;
    localparam logic [CMP_W-1:0] LIMIT = CMP_W'(1) << TICK_W;

    localparam logic [PHASE_W-1:0] PH_IDLE     = 4'd0;
    localparam logic [PHASE_W-1:0] PH_WAKE_HI  = 4'd1;
    localparam logic [PHASE_W-1:0] PH_WAKE_DRV = 4'd2;
    localparam logic [PHASE_W-1:0] PH_WAKE_LO  = 4'd3;
    localparam logic [PHASE_W-1:0] PH_TURN     = 4'd4;
    localparam logic [PHASE_W-1:0] PH_RD_LO    = 4'd5;
    localparam logic [PHASE_W-1:0] PH_RD_HI    = 4'd6;
    localparam logic [PHASE_W-1:0] PH_WR_HI    = 4'd7;
    localparam logic [PHASE_W-1:0] PH_WR_LO    = 4'd8;

    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic [TICK_W-1:0]   tick_reg, tick_next;
    logic [BITCNT_W-1:0] bit_reg, bit_next;
    logic [FRAME_W-1:0]  rx_reg, rx_next;
    logic [TX_W-1:0]     tx_reg, tx_next;
    logic [CMP_W-1:0]    hp_eff;

    always_comb
    begin
        hp_eff = CMP_W'(hp_cfg);
        if (hp_cfg == '0)
        begin
            hp_eff = CMP_W'(1);
        end
        else if (hp_eff > LIMIT)
        begin
            hp_eff = LIMIT;
        end
    end

    always_comb
    begin
        logic [CMP_W-1:0]    t;
        logic [BITCNT_W-1:0] bc_inc;
        logic                clk_lvl;
        logic                drv;
        logic                dout;
        logic [STATUS_W-1:0] st;
        logic [CODE_W-1:0]   cd;
        phase_next = phase_reg;
        tick_next  = tick_reg;
        bit_next   = bit_reg;
        rx_next    = rx_reg;
        tx_next    = tx_reg;
        st         = ST_NONE;
        cd         = '0;
        clk_lvl    = 1'b0;
        drv        = 1'b0;
        dout       = 1'b0;

        // start a transfer, or report not ready when a poll sees sda high
        if (phase_reg == PH_IDLE)
        begin
            if (opcode == OP_POLL)
            begin
                if (sda_in)
                begin
                    st = ST_NOT_READY;
                end
                else
                begin
                    phase_next = PH_WAKE_HI;
                    tick_next  = '0;
                    bit_next   = '0;
                    rx_next    = '0;
                end
            end
            else if (opcode == OP_CMD)
            begin
                phase_next = PH_WR_HI;
                tick_next  = '0;
                bit_next   = '0;
                tx_next    = {1'b1, cmd_byte};
            end
        end

        // pin levels for this tick
        unique case (phase_next)
            PH_WAKE_HI:  begin clk_lvl = 1'b1; drv = 1'b0; end
            PH_WAKE_DRV: begin clk_lvl = 1'b1; drv = 1'b1; end
            PH_WAKE_LO:  begin clk_lvl = 1'b0; drv = 1'b1; end
            PH_TURN:     begin clk_lvl = 1'b1; drv = 1'b0; end
            PH_RD_LO:    begin clk_lvl = 1'b0; drv = 1'b0; end
            PH_RD_HI:    begin clk_lvl = 1'b1; drv = 1'b0; end
            PH_WR_HI:
            begin
                clk_lvl = 1'b1;
                drv     = 1'b1;
                dout    = tx_next[TX_W-1];
            end
            PH_WR_LO:
            begin
                clk_lvl = 1'b0;
                drv     = 1'b1;
                dout    = tx_next[TX_W-1];
            end
            default:
            begin
                phase_next = PH_IDLE;
                clk_lvl    = 1'b0;
                drv        = 1'b0;
            end
        endcase

        // advance tick and phase
        t      = CMP_W'(tick_next) + CMP_W'(1);
        bc_inc = bit_next + BITCNT_W'(1);
        if (phase_next != PH_IDLE)
        begin
            if (t < hp_eff)
            begin
                tick_next = t[TICK_W-1:0];
            end
            else
            begin
                tick_next = '0;
                unique case (phase_next)
                    PH_WAKE_HI:  phase_next = PH_WAKE_DRV;
                    PH_WAKE_DRV: phase_next = PH_WAKE_LO;
                    PH_WAKE_LO:  phase_next = PH_TURN;
                    PH_TURN:     phase_next = PH_RD_LO;
                    PH_RD_HI:    phase_next = PH_RD_LO;
                    PH_RD_LO:
                    begin
                        rx_next  = {rx_next[FRAME_W-2:0], sda_in};
                        bit_next = bc_inc;
                        if (bc_inc >= FRAME_BITS)
                        begin
                            phase_next = PH_IDLE;
                            st         = frame_check(rx_next);
                            if (st == ST_VALID)
                            begin
                                cd = CODE_W'(rx_next[15:0]) + CODE_W'(1);
                            end
                        end
                        else
                        begin
                            phase_next = PH_RD_HI;
                        end
                    end
                    PH_WR_HI:    phase_next = PH_WR_LO;
                    default:
                    begin
                        tx_next  = {tx_next[TX_W-2:0], 1'b0};
                        bit_next = bc_inc;
                        if (bc_inc >= TX_BITS)
                        begin
                            phase_next = PH_IDLE;
                            st         = ST_CMD_SENT;
                        end
                        else
                        begin
                            phase_next = PH_WR_HI;
                        end
                    end
                endcase
            end
        end

        result.sck       = clk_lvl;
        result.sda_out   = drv & dout;
        result.sda_drive = drv;
        result.busy      = (phase_next != PH_IDLE);
        result.status    = st;
        result.frame     = rx_next;
        result.code      = cd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            tick_reg  <= '0;
            bit_reg   <= '0;
            rx_reg    <= '0;
            tx_reg    <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            bit_reg   <= bit_next;
            rx_reg    <= rx_next;
            tx_reg    <= tx_next;
        end
    end

endmodule

[rtl/core/oid_out_buf.sv]
// Result register with a skid entry, so the core keeps running under a short stall.
// Depends on oid_pkg.
module oid_out_buf
    import oid_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    skid_full,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t out_data
);

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg;
    result_t skid_reg;
    logic    take;

    assign take = main_valid_reg & ~out_stall;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (main_valid_reg && !take)
            begin
                skid_valid_next = 1'b1;
            end
            else
            begin
                main_valid_next = 1'b1;
            end
        end
        else if (take)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                main_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (main_valid_reg && !take)
            begin
                skid_reg <= push_data;
            end
            else
            begin
                main_reg <= push_data;
            end
        end
    end

    assign skid_full = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

endmodule

[rtl/core/optical_id_two_wire_host.sv]
// Host side of a two-wire optical-ID sensor link, one bit-bang tick per item.
// Throughput: one item per cycle while in_stall is low (it rises when the skid
// entry is full); each item goes through the input register, the sequencer
// logic and the result register with a skid entry.
// Reset: sequencer idle, counters and shift registers zero, half period 48.
// Depends on oid_pkg, oid_core, oid_out_buf.
module optical_id_two_wire_host
    import oid_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [HP_W-1:0]     cfg_wr_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [OPCODE_W-1:0] opcode,
    input  logic [CMD_W-1:0]    cmd_byte,
    input  logic                sda_in,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                sck,
    output logic                sda_out,
    output logic                sda_drive,
    output logic                busy_res,
    output logic [STATUS_W-1:0] status,
    output logic [FRAME_W-1:0]  frame,
    output logic [CODE_W-1:0]   code
);

    logic [HP_W-1:0]     hp_reg;
    logic                in_valid_reg;
    logic [OPCODE_W-1:0] opcode_reg;
    logic [CMD_W-1:0]    cmd_reg;
    logic                sda_reg;
    logic                skid_full;
    logic                advance;
    logic                in_take;
    result_t             core_res;
    result_t             out_res;

    assign advance  = in_valid_reg & ~skid_full;
    assign in_stall = in_valid_reg & skid_full;
    assign in_take  = in_valid & ~in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hp_reg       <= HP_RESET;
            in_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                hp_reg <= cfg_wr_data;
            end
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            opcode_reg <= opcode;
            cmd_reg    <= cmd_byte;
            sda_reg    <= sda_in;
        end
    end

    oid_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .hp_cfg   (hp_reg),
        .advance  (advance),
        .opcode   (opcode_reg),
        .cmd_byte (cmd_reg),
        .sda_in   (sda_reg),
        .result   (core_res)
    );

    oid_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (advance),
        .push_data (core_res),
        .skid_full (skid_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_res)
    );

    assign sck       = out_res.sck;
    assign sda_out   = out_res.sda_out;
    assign sda_drive = out_res.sda_drive;
    assign busy_res  = out_res.busy;
    assign status    = out_res.status;
    assign frame     = out_res.frame;
    assign code      = out_res.code;

    a_code_on_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_VALID |-> code != '0)
        else $error("valid frame reported with zero code");

    a_code_otherwise_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_VALID |-> code == '0)
        else $error("code set without a valid frame");

    a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full |-> out_valid)
        else $error("skid entry held while result register empty");

    a_busy_done_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && busy_res |-> status == ST_NONE)
        else $error("status reported during a running transfer");

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// Testbench for optical_id_two_wire_host: predicts pin levels, status, frame and code per tick.
// Needs oid_pkg and the RTL of the host; directed tests first, then random traffic with stalls.
module tb;
    import oid_pkg::*;

    localparam logic [OPCODE_W-1:0] OP_RSVD = 2'd3;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 8;

    typedef enum logic [PHASE_W-1:0] {
        SEQ_IDLE,
        SEQ_WAKE_HI,
        SEQ_WAKE_DRV,
        SEQ_WAKE_LO,
        SEQ_TURN,
        SEQ_RD_LO,
        SEQ_RD_HI,
        SEQ_WR_HI,
        SEQ_WR_LO
    } seq_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [HP_W-1:0]     cfg_wr_data = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [OPCODE_W-1:0] opcode = OP_NONE;
    logic [CMD_W-1:0]    cmd_byte = '0;
    logic                sda_in = 1'b0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                sck;
    logic                sda_out;
    logic                sda_drive;
    logic                busy_res;
    logic [STATUS_W-1:0] status;
    logic [FRAME_W-1:0]  frame;
    logic [CODE_W-1:0]   code;

    // predicted sequencer state
    seq_t                seq = SEQ_IDLE;
    logic [HP_W-1:0]     half_ticks = HP_RESET;
    int unsigned         tick_cnt = 0;
    logic [BITCNT_W-1:0] rd_bits = '0;
    logic [FRAME_W-1:0]  rx_frame = '0;
    logic [TX_W-1:0]     tx_bits = '0;
    logic                pin_clk = 1'b0;
    logic                pin_drv = 1'b0;

    logic [FRAME_W-1:0]  rd_target = '0;
    result_t             tick_exp_q[$];

    int send_idle_pct = 0;
    int stall_pct = 0;
    int mismatches = 0;
    int ticks_sent = 0;
    int results_checked = 0;
    int idle_cycles = 0;
    int n_valid = 0;
    int n_invalid = 0;
    int n_not_ready = 0;
    int n_sent = 0;

    optical_id_two_wire_host i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .cmd_byte    (cmd_byte),
        .sda_in      (sda_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .sck         (sck),
        .sda_out     (sda_out),
        .sda_drive   (sda_drive),
        .busy_res    (busy_res),
        .status      (status),
        .frame       (frame),
        .code        (code)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [STATUS_W-1:0] grade_frame(input logic [FRAME_W-1:0] f);
        logic [6:0]  hdr;
        logic [15:0] low;
        hdr = f[22:16];
        low = f[15:0];
        if (f == '0)
            return ST_INVALID;
        if (hdr[1:0] != 2'b00)
            return (low >= 16'hFFFB) ? ST_INVALID : ST_VALID;
        if (!hdr[6] || hdr[5] || low == 16'hFFFF)
            return ST_INVALID;
        return ST_VALID;
    endfunction

    function automatic result_t step_link(input logic [OPCODE_W-1:0] op,
                                          input logic [CMD_W-1:0] cmd, input logic sda);
        result_t             r;
        int unsigned         hp;
        logic [STATUS_W-1:0] st;
        logic [CODE_W-1:0]   cd;
        logic                dout;
        hp = (half_ticks == '0) ? 1 : half_ticks;
        st = ST_NONE;
        cd = '0;
        dout = 1'b0;
        if (seq == SEQ_IDLE)
        begin
            if (op == OP_POLL)
            begin
                if (sda)
                begin
                    st = ST_NOT_READY;
                end
                else
                begin
                    seq = SEQ_WAKE_HI;
                    tick_cnt = 0;
                    rd_bits = '0;
                    rx_frame = '0;
                end
            end
            else if (op == OP_CMD)
            begin
                seq = SEQ_WR_HI;
                tick_cnt = 0;
                rd_bits = '0;
                tx_bits = {1'b1, cmd};
            end
        end
        case (seq)
            SEQ_WAKE_HI:  begin pin_clk = 1'b1; pin_drv = 1'b0; end
            SEQ_WAKE_DRV: begin pin_clk = 1'b1; pin_drv = 1'b1; end
            SEQ_WAKE_LO:  begin pin_clk = 1'b0; pin_drv = 1'b1; end
            SEQ_TURN:     begin pin_clk = 1'b1; pin_drv = 1'b0; end
            SEQ_RD_LO:    begin pin_clk = 1'b0; pin_drv = 1'b0; end
            SEQ_RD_HI:    begin pin_clk = 1'b1; pin_drv = 1'b0; end
            SEQ_WR_HI:    begin pin_clk = 1'b1; pin_drv = 1'b1; dout = tx_bits[TX_W-1]; end
            SEQ_WR_LO:    begin pin_clk = 1'b0; pin_drv = 1'b1; dout = tx_bits[TX_W-1]; end
            default:      begin seq = SEQ_IDLE; pin_clk = 1'b0; pin_drv = 1'b0; end
        endcase
        if (seq != SEQ_IDLE)
        begin
            if (tick_cnt + 1 < hp)
            begin
                tick_cnt = tick_cnt + 1;
            end
            else
            begin
                tick_cnt = 0;
                case (seq)
                    SEQ_WAKE_HI:  seq = SEQ_WAKE_DRV;
                    SEQ_WAKE_DRV: seq = SEQ_WAKE_LO;
                    SEQ_WAKE_LO:  seq = SEQ_TURN;
                    SEQ_TURN:     seq = SEQ_RD_LO;
                    SEQ_RD_HI:    seq = SEQ_RD_LO;
                    SEQ_WR_HI:    seq = SEQ_WR_LO;
                    SEQ_RD_LO:
                    begin
                        rx_frame = {rx_frame[FRAME_W-2:0], sda};
                        rd_bits = rd_bits + 1'b1;
                        if (rd_bits >= FRAME_BITS)
                        begin
                            seq = SEQ_IDLE;
                            st = grade_frame(rx_frame);
                            if (st == ST_VALID)
                                cd = {1'b0, rx_frame[15:0]} + 1'b1;
                        end
                        else
                        begin
                            seq = SEQ_RD_HI;
                        end
                    end
                    default:
                    begin
                        tx_bits = {tx_bits[TX_W-2:0], 1'b0};
                        rd_bits = rd_bits + 1'b1;
                        if (rd_bits >= TX_BITS)
                        begin
                            seq = SEQ_IDLE;
                            st = ST_CMD_SENT;
                        end
                        else
                        begin
                            seq = SEQ_WR_HI;
                        end
                    end
                endcase
            end
        end
        r.sck = pin_clk;
        r.sda_out = pin_drv ? dout : 1'b0;
        r.sda_drive = pin_drv;
        r.busy = (seq != SEQ_IDLE);
        r.status = st;
        r.frame = rx_frame;
        r.code = cd;
        if (seq == SEQ_IDLE)
        begin
            pin_clk = 1'b0;
            pin_drv = 1'b0;
        end
        case (st)
            ST_VALID:     n_valid++;
            ST_INVALID:   n_invalid++;
            ST_NOT_READY: n_not_ready++;
            ST_CMD_SENT:  n_sent++;
            default:      ;
        endcase
        return r;
    endfunction

    function automatic logic [FRAME_W-1:0] pick_frame();
        logic [6:0]  hdr;
        logic [15:0] low;
        hdr = 7'($urandom);
        low = 16'($urandom);
        case ($urandom_range(9))
            0, 1:
            begin
                hdr[1:0] = 2'($urandom_range(3, 1));
                low = 16'($urandom_range(16'hFFFA));
            end
            2, 3:
            begin
                hdr = {2'b10, hdr[4:2], 2'b00};
                low = 16'($urandom_range(16'hFFFE));
            end
            4:
            begin
                hdr[1:0] = 2'($urandom_range(3, 1));
                low = 16'($urandom_range(16'hFFFF, 16'hFFF9));
            end
            5:
            begin
                hdr = {2'b10, hdr[4:2], 2'b00};
                low = 16'($urandom_range(16'hFFFF, 16'hFFFD));
            end
            6:    begin hdr = '0; low = $urandom_range(1) ? '0 : low; end
            7:    begin hdr[1:0] = 2'b00; hdr[5] = hdr[5] | !hdr[6]; end
            default: ;
        endcase
        return {hdr, low};
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want_v,
                                        input logic [31:0] got_v);
        if (want_v !== got_v)
        begin
            $error("%s: expected %0h, got %0h", name, want_v, got_v);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (tick_exp_q.size() == 0)
            begin
                $error("result with no item pending: status %0d frame %0h", status, frame);
                mismatches++;
            end
            else
            begin
                want = tick_exp_q.pop_front();
                check_field("sck", 32'(want.sck), 32'(sck));
                check_field("sda_out", 32'(want.sda_out), 32'(sda_out));
                check_field("sda_drive", 32'(want.sda_drive), 32'(sda_drive));
                check_field("busy_res", 32'(want.busy), 32'(busy_res));
                check_field("status", 32'(want.status), 32'(status));
                check_field("frame", 32'(want.frame), 32'(frame));
                check_field("code", 32'(want.code), 32'(code));
                results_checked++;
            end
        end
        out_stall <= ($urandom_range(99) < stall_pct);
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_tick(input logic [OPCODE_W-1:0] op, input logic [CMD_W-1:0] cmd,
                             input logic sda);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        cmd_byte <= cmd;
        sda_in <= sda;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tick_exp_q.push_back(step_link(op, cmd, sda));
        ticks_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (tick_exp_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_half_period(input logic [HP_W-1:0] value);
        drain_results();
        repeat (4) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        half_ticks = value;
    endtask

    task automatic random_tick();
        logic [OPCODE_W-1:0] op;
        logic [CMD_W-1:0]    cmd;
        logic                sda;
        int                  pick;
        cmd = CMD_W'($urandom);
        sda = 1'($urandom_range(1));
        pick = $urandom_range(99);
        if (seq == SEQ_IDLE)
        begin
            if (pick < 45)
            begin
                op = OP_POLL;
                sda = ($urandom_range(9) == 0);
                if (!sda)
                    rd_target = pick_frame();
            end
            else if (pick < 75)
                op = OP_CMD;
            else if (pick < 88)
                op = OP_NONE;
            else
                op = OP_RSVD;
        end
        else
        begin
            op = (pick < 80) ? OP_NONE : OPCODE_W'($urandom_range(3));
            if (seq == SEQ_RD_LO || seq == SEQ_RD_HI)
            begin
                sda = rd_target[FRAME_W-1-rd_bits];
                if ($urandom_range(49) == 0)
                    sda = ~sda;
            end
        end
        send_tick(op, cmd, sda);
    endtask

    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [OPCODE_W-1:0] busy_op);
        send_tick(OP_CMD, cmd, 1'b0);
        while (seq != SEQ_IDLE)
            send_tick(busy_op, ~cmd, 1'($urandom_range(1)));
    endtask

    task automatic read_frame(input logic [FRAME_W-1:0] target);
        rd_target = target;
        send_tick(OP_POLL, 8'h00, 1'b0);
        while (seq != SEQ_IDLE)
        begin
            if (seq == SEQ_RD_LO || seq == SEQ_RD_HI)
                send_tick(OP_CMD, 8'hFF, rd_target[FRAME_W-1-rd_bits]);
            else
                send_tick(OP_NONE, 8'h00, 1'b1);
        end
    endtask

    task automatic test_requests_at_rest();
        send_tick(OP_NONE, 8'h00, 1'b0);
        send_tick(OP_RSVD, 8'hFF, 1'b1);
        send_tick(OP_POLL, 8'hFF, 1'b1);
        send_tick(OP_POLL, 8'h00, 1'b1);
        drain_results();
    endtask

    task automatic test_command_path();
        set_half_period(16'd0);
        send_command(8'hFF, OP_POLL);
        send_command(8'h00, OP_RSVD);
        drain_results();
    endtask

    task automatic test_frame_read();
        set_half_period(16'd1);
        read_frame(23'h40_FFFE);
        read_frame(23'h00_0000);
        drain_results();
    endtask

    task automatic test_random_traffic(input logic [HP_W-1:0] hp, input int n,
                                       input int idle_pct, input int hold_pct);
        set_half_period(hp);
        send_idle_pct = idle_pct;
        stall_pct = hold_pct;
        for (int i = 0; i < n; i++)
        begin
            if (i == n / 2)
                drain_results();
            random_tick();
        end
        drain_results();
    endtask

    task automatic test_slow_clock();
        set_half_period(16'hFFFF);
        send_idle_pct = 0;
        stall_pct = 0;
        rd_target = pick_frame();
        send_tick(OP_POLL, 8'h00, 1'b0);
        for (int i = 0; i < 60; i++)
            random_tick();
        drain_results();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_requests_at_rest();
        test_command_path();
        test_frame_read();
        test_random_traffic(16'd1, 190, 0, 0);
        test_random_traffic(16'd2, 170, 61, 0);
        test_random_traffic(16'd0, 170, 0, 61);
        test_slow_clock();
        test_random_traffic(16'd3, 170, 27, 27);
        stall_pct = 0;
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (tick_exp_q.size() != 0)
        begin
            $error("%0d results never arrived", tick_exp_q.size());
            mismatches++;
        end
        $display("Covered %0d ticks at half periods 0 to 65535: %0d valid and %0d invalid frames,",
                 ticks_sent, n_valid, n_invalid);
        $display("%0d not-ready polls, %0d commands sent, %0d results checked, %0d mismatches.",
                 n_not_ready, n_sent, results_checked, mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[optical_id_two_wire_host.f]
rtl/core/oid_pkg.sv
rtl/core/oid_core.sv
rtl/core/oid_out_buf.sv
rtl/core/optical_id_two_wire_host.sv
verif/tb.sv
